>>> hdl/masked_power_moment_accumulator_unit_macros.svh
// Assertion macros shared by the power moment accumulator RTL.
`ifndef MASKED_POWER_MOMENT_ACCUMULATOR_UNIT_MACROS_SVH
`define MASKED_POWER_MOMENT_ACCUMULATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: whenever ante holds, cons holds as well.
`define MPMA_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication: whenever ante holds, cons holds at the following clock.
`define MPMA_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPMA_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define MPMA_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

>>> hdl/mpma_pkg.sv
// Package with widths, register codes and shared types of the power moment accumulator.
`default_nettype none
package mpma_pkg;
  localparam int MAX_CHANNELS = 4096;
  localparam int MAX_WINDOW   = 1024;
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WIN_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  localparam int CCOUNT_W   = 13;
  localparam int WLEN_W     = 11;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam int BYTE_W   = 8;
  localparam int NIB_W    = 4;
  localparam int SQ_W     = 7;
  localparam int E2_W     = 8;
  localparam int E4_W     = 15;
  localparam int OUT_CH_W = 12;
  localparam int CNT_W    = 11;
  localparam int PWR_W    = 18;
  localparam int PSQ_W    = 25;

  localparam logic [BYTE_W-1:0] NIB_LO = 8'h0f;
  localparam logic [BYTE_W-1:0] NIB_HI = 8'hf0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 1'b0,
    REG_WINDOW_LENGTH = 1'b1
  } cfg_reg_t;

  // One classified sample on its way from the front end to the accumulator.
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            keep;
    logic [E2_W-1:0] e2;
    logic [E4_W-1:0] e4;
    logic            last_win;
    logic            last_ch;
  } work_t;

  // Per-channel partial sums as kept in the store.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [PWR_W-1:0] pwr;
    logic [PSQ_W-1:0] psq;
  } sums_t;

  localparam int SUMS_W = $bits(sums_t);

  // Occupancy flags of the queue between front end and accumulator.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;
endpackage
`default_nettype wire

>>> hdl/mpma_in_if.sv
// Sample channel interface: voltage byte and mask bit.
`default_nettype none
interface mpma_in_if;
  logic                            valid;
  logic                            ready;
  logic [mpma_pkg::BYTE_W-1:0]     sample_byte;
  logic                            mask_bit;
  modport source (output valid, sample_byte, mask_bit, input ready);
  modport sink   (input valid, sample_byte, mask_bit, output ready);
endinterface
`default_nettype wire

>>> hdl/mpma_out_if.sv
// Result channel interface: one channel's window sums.
`default_nettype none
interface mpma_out_if;
  logic                          valid;
  logic                          ready;
  logic [mpma_pkg::OUT_CH_W-1:0] channel_index;
  logic [mpma_pkg::CNT_W-1:0]    sum_count;
  logic [mpma_pkg::PWR_W-1:0]    sum_power;
  logic [mpma_pkg::PSQ_W-1:0]    sum_power_sq;
  logic                          last_channel;
  modport source (output valid, channel_index, sum_count, sum_power, sum_power_sq,
                  last_channel, input ready);
  modport sink   (input valid, channel_index, sum_count, sum_power, sum_power_sq,
                  last_channel, output ready);
endinterface
`default_nettype wire

>>> hdl/mpma_cfg_if.sv
// Configuration write interface: register index and write data.
`default_nettype none
interface mpma_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mpma_pkg::CFG_IDX_W-1:0]  index;
  logic [mpma_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/mpma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mpma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> hdl/mpma_front.sv
// Front end: configuration registers, channel and window counters, power terms.
`default_nettype none
module mpma_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  mpma_cfg_if.sink                  cfg,
  mpma_in_if.sink                   samples,
  input  wire mpma_pkg::q_status_t  q_status,
  input  wire logic                 block,
  output logic                      push,
  output mpma_pkg::work_t           push_item
);
  logic [mpma_pkg::CCOUNT_W-1:0] channel_count;
  logic [mpma_pkg::WLEN_W-1:0]   window_length;
  logic [mpma_pkg::CH_W-1:0]     channel_counter;
  logic [mpma_pkg::WIN_W-1:0]    window_counter;

  logic [mpma_pkg::CH_W-1:0]     nch_last;
  logic [mpma_pkg::WIN_W-1:0]    win_last;
  logic [mpma_pkg::CH_W-1:0]     ch;
  logic [mpma_pkg::WIN_W-1:0]    win;
  logic                          last_ch;
  logic                          last_win;
  logic signed [mpma_pkg::NIB_W-1:0] re_part;
  logic signed [mpma_pkg::NIB_W-1:0] im_part;
  logic [mpma_pkg::SQ_W-1:0]     re_sq;
  logic [mpma_pkg::SQ_W-1:0]     im_sq;
  logic [mpma_pkg::E2_W-1:0]     e2;
  logic [2*mpma_pkg::E2_W-1:0]   e4_full;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= mpma_pkg::CCOUNT_W'(4096);
      window_length <= mpma_pkg::WLEN_W'(256);
    end else if (cfg.valid) begin
      unique case (mpma_pkg::cfg_reg_t'(cfg.index))
        mpma_pkg::REG_CHANNEL_COUNT: channel_count <= cfg.data;
        mpma_pkg::REG_WINDOW_LENGTH: window_length <= cfg.data[mpma_pkg::WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective last channel and last time sample of a window.
  always_comb begin
    if (channel_count == '0) begin
      nch_last = '0;
    end else if (32'(channel_count) > mpma_pkg::MAX_CHANNELS) begin
      nch_last = mpma_pkg::CH_W'(mpma_pkg::MAX_CHANNELS - 1);
    end else begin
      nch_last = mpma_pkg::CH_W'(channel_count - mpma_pkg::CCOUNT_W'(1));
    end
    if (window_length == '0) begin
      win_last = '0;
    end else if (32'(window_length) > mpma_pkg::MAX_WINDOW) begin
      win_last = mpma_pkg::WIN_W'(mpma_pkg::MAX_WINDOW - 1);
    end else begin
      win_last = mpma_pkg::WIN_W'(window_length - mpma_pkg::WLEN_W'(1));
    end
  end

  // A counter left beyond a shrunk range wraps (channel) or closes the window.
  assign ch       = (channel_counter > nch_last) ? '0 : channel_counter;
  assign win      = (window_counter > win_last) ? win_last : window_counter;
  assign last_ch  = (ch == nch_last);
  assign last_win = (win == win_last);

  // Flipping the top bit of an offset-by-8 nibble gives its two's complement value.
  assign re_part = {~samples.sample_byte[7], samples.sample_byte[6:4]
                    & mpma_pkg::NIB_HI[6:4]};
  assign im_part = {~samples.sample_byte[3], samples.sample_byte[2:0]
                    & mpma_pkg::NIB_LO[2:0]};
  assign re_sq   = mpma_pkg::SQ_W'(re_part * re_part);
  assign im_sq   = mpma_pkg::SQ_W'(im_part * im_part);
  assign e2      = mpma_pkg::E2_W'(re_sq) + mpma_pkg::E2_W'(im_sq);
  assign e4_full = e2 * e2;

  assign samples.ready = !q_status.full && !block;
  assign push          = samples.valid && samples.ready;

  always_comb begin
    push_item.ch       = ch;
    push_item.keep     = samples.mask_bit;
    push_item.e2       = e2;
    push_item.e4       = e4_full[mpma_pkg::E4_W-1:0];
    push_item.last_win = last_win;
    push_item.last_ch  = last_ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_counter <= '0;
      window_counter  <= '0;
    end else if (push) begin
      if (last_ch) begin
        channel_counter <= '0;
        window_counter  <= last_win ? '0 : win + mpma_pkg::WIN_W'(1);
      end else begin
        channel_counter <= ch + mpma_pkg::CH_W'(1);
        window_counter  <= win;
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/mpma_queue.sv
// Short FIFO of classified samples between front end and accumulator.
`default_nettype none
module mpma_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire mpma_pkg::work_t      push_item,
  input  wire logic                 pop,
  output mpma_pkg::work_t           head,
  output mpma_pkg::q_status_t       status
);
  mpma_pkg::work_t               entries [mpma_pkg::QUEUE_DEPTH];
  logic [mpma_pkg::QPTR_W-1:0]   wr_ptr;
  logic [mpma_pkg::QPTR_W-1:0]   rd_ptr;
  logic [mpma_pkg::QPTR_W:0]     count;

  assign status = mpma_pkg::q_status_t'{
    full:  (count == (mpma_pkg::QPTR_W + 1)'(mpma_pkg::QUEUE_DEPTH)),
    empty: (count == '0)
  };
  assign head   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mpma_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mpma_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (mpma_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (mpma_pkg::QPTR_W + 1)'(1);
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/mpma_back.sv
// Accumulator: per-channel store, read-modify-write with forwarding, result register.
`default_nettype none
`include "masked_power_moment_accumulator_unit_macros.svh"
module mpma_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mpma_pkg::q_status_t  q_status,
  input  wire mpma_pkg::work_t      q_head,
  output logic                      pop,
  output logic                      clearing,
  mpma_out_if.source                results
);
  logic [mpma_pkg::CH_W-1:0]     clr_addr;
  logic                          s1_valid;
  mpma_pkg::work_t               s1_item;
  logic                          fwd_valid;
  mpma_pkg::sums_t               fwd_data;

  logic [mpma_pkg::SUMS_W-1:0]   rdata;
  mpma_pkg::sums_t               old_sums;
  mpma_pkg::sums_t               new_sums;
  logic [mpma_pkg::CNT_W:0]      cnt_sum;
  logic [mpma_pkg::PWR_W:0]      pwr_sum;
  logic [mpma_pkg::PSQ_W:0]      psq_sum;
  logic                          s1_fire;
  logic                          same_ch;
  logic                          close_fire;
  logic                          ram_we;
  logic [mpma_pkg::CH_W-1:0]     ram_waddr;
  mpma_pkg::sums_t               ram_wdata;

  mpma_ram #(
    .WIDTH (mpma_pkg::SUMS_W),
    .DEPTH (mpma_pkg::MAX_CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (q_head.ch),
    .rdata (rdata)
  );

  // The store read for the item in stage one misses a write made in the same
  // cycle to the same channel; that value is held aside and used instead.
  assign old_sums = fwd_valid ? fwd_data : mpma_pkg::sums_t'(rdata);

  assign cnt_sum = {1'b0, old_sums.cnt} + (mpma_pkg::CNT_W + 1)'(1);
  assign pwr_sum = {1'b0, old_sums.pwr} + (mpma_pkg::PWR_W + 1)'(s1_item.e2);
  assign psq_sum = {1'b0, old_sums.psq} + (mpma_pkg::PSQ_W + 1)'(s1_item.e4);

  always_comb begin
    if (s1_item.keep) begin
      new_sums.cnt = cnt_sum[mpma_pkg::CNT_W] ? '1 : cnt_sum[mpma_pkg::CNT_W-1:0];
      new_sums.pwr = pwr_sum[mpma_pkg::PWR_W] ? '1 : pwr_sum[mpma_pkg::PWR_W-1:0];
      new_sums.psq = psq_sum[mpma_pkg::PSQ_W] ? '1 : psq_sum[mpma_pkg::PSQ_W-1:0];
    end else begin
      new_sums = old_sums;
    end
  end

  assign s1_fire    = s1_valid && (!s1_item.last_win || !results.valid || results.ready);
  assign pop        = !clearing && !q_status.empty && (!s1_valid || s1_fire);
  assign same_ch    = s1_fire && (s1_item.ch == q_head.ch);
  assign close_fire = s1_fire && s1_item.last_win;

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_fire;
      ram_waddr = s1_item.ch;
      ram_wdata = s1_item.last_win ? '0 : new_sums;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + mpma_pkg::CH_W'(1);
      if (clr_addr == mpma_pkg::CH_W'(mpma_pkg::MAX_CHANNELS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else if (pop) begin
      s1_valid  <= 1'b1;
      fwd_valid <= same_ch;
    end else if (s1_fire) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item  <= q_head;
      fwd_data <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (close_fire) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (close_fire) begin
      results.channel_index <= mpma_pkg::OUT_CH_W'(s1_item.ch);
      results.sum_count     <= new_sums.cnt;
      results.sum_power     <= new_sums.pwr;
      results.sum_power_sq  <= new_sums.psq;
      results.last_channel  <= s1_item.last_ch;
    end
  end

  `MPMA_ASSERT_IMP(a_idle_clearing, clk, rst, clearing, !pop && !s1_valid, "work during clear")
  `MPMA_ASSERT_NEXT(a_forward_armed, clk, rst, pop && same_ch, fwd_valid, "write not forwarded")
  `MPMA_ASSERT_NEXT(a_result_loaded, clk, rst, close_fire, results.valid, "result not loaded")
endmodule
`default_nettype wire

>>> hdl/masked_power_moment_accumulator_unit.sv
// Top level of the masked power moment accumulator (spectral kurtosis power sums).
`default_nettype none
// This block takes one voltage word per cycle while samples.ready is high (a 4+4 bit
// complex byte, offset by 8, with its mask bit), channel-fastest within a time sample, and
// keeps for every channel the count of unmasked samples, the sum of their power and the
// sum of their squared power. On the last time sample of a window the channel's three
// sums, including that sample, leave on the result channel as one word, and the channel's
// store starts over from zero. The sustained rate is one sample word per clock while the
// result side does not stall; the per-channel store is a single RAM with one write and
// one registered read port, and back-to-back samples of the same channel are served by
// forwarding the value just written. After reset the 4096 store entries are cleared one
// entry per cycle; samples.ready stays low during that sweep, while configuration writes
// are taken at any time. A sample reaches the accumulator through a four-word queue, so
// a stall on the result side first fills the queue and then lowers samples.ready. The
// result word is registered behind stage one. The channel count (register 0) and window
// length (register 1) are meant to be written only while the block is idle; zero is
// taken as one and values above the supported maximum saturate to it.
module masked_power_moment_accumulator_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  mpma_cfg_if.sink   cfg,
  mpma_in_if.sink    samples,
  mpma_out_if.source results
);
  mpma_pkg::q_status_t q_status;
  mpma_pkg::work_t     push_item;
  mpma_pkg::work_t     q_head;
  logic                push;
  logic                pop;
  logic                clearing;

  // Front end: counts channels and time samples and computes |e|^2 and |e|^4.
  mpma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .samples   (samples),
    .q_status  (q_status),
    .block     (clearing),
    .push      (push),
    .push_item (push_item)
  );

  // Decouples the front end from the store so each side can stall on its own.
  mpma_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .status    (q_status)
  );

  // Back end: updates the channel store and presents finished windows.
  mpma_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_head   (q_head),
    .pop      (pop),
    .clearing (clearing),
    .results  (results)
  );
endmodule
`default_nettype wire
